@@ rtl/core/sekcg_pkg.sv @@
// ----------------------------------------------------------------------------
// sekcg_pkg: shared types and constants of the kernel element engine
// Payload structs, divider handshake structs, fixed-point constants, exp table.
// ----------------------------------------------------------------------------
package sekcg_pkg;

    localparam logic [1:0] CFG_LENGTH_SCALE   = 2'd0;
    localparam logic [1:0] CFG_VERTICAL_SCALE = 2'd1;
    localparam logic [1:0] CFG_NOISE_LEVEL    = 2'd2;

    localparam logic [30:0] LENGTH_RESET   = 31'd16777216;
    localparam logic [30:0] VERTICAL_RESET = 31'd16777216;
    localparam logic [30:0] NOISE_RESET    = 31'd1677722;

    localparam logic [24:0] ONE24  = 25'd16777216;
    localparam logic [30:0] ONE30  = 31'd1073741824;
    localparam logic [31:0] SAT32  = 32'h7FFF_FFFF;
    localparam logic [29:0] X_CAP  = 30'h3FFF_FFFF;
    localparam logic [4:0]  EXP_BITS = 5'd29;
    localparam logic [4:0]  DIV_ITERS_X = 5'd30;
    localparam logic [4:0]  DIV_ITERS_L = 5'd31;

    typedef struct packed {
        logic signed [31:0] feature_a;
        logic signed [31:0] feature_b;
        logic               last_feature;
        logic [15:0]        point_row;
        logic [15:0]        point_col;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] covariance;
        logic signed [31:0] grad_vertical;
        logic signed [31:0] grad_length;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [61:0] rem_init;
        logic [30:0] low;
        logic [4:0]  iters;
        logic [61:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [30:0] quot;
    } div_rsp_t;

    // exp(-2^(i-24)) in Q.30
    function automatic logic [30:0] exp_tab(input logic [4:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd0:  v = 31'd1073741760;
            5'd1:  v = 31'd1073741696;
            5'd2:  v = 31'd1073741568;
            5'd3:  v = 31'd1073741312;
            5'd4:  v = 31'd1073740800;
            5'd5:  v = 31'd1073739776;
            5'd6:  v = 31'd1073737728;
            5'd7:  v = 31'd1073733632;
            5'd8:  v = 31'd1073725440;
            5'd9:  v = 31'd1073709056;
            5'd10: v = 31'd1073676290;
            5'd11: v = 31'd1073610760;
            5'd12: v = 31'd1073479712;
            5'd13: v = 31'd1073217664;
            5'd14: v = 31'd1072693760;
            5'd15: v = 31'd1071646719;
            5'd16: v = 31'd1069555701;
            5'd17: v = 31'd1065385899;
            5'd18: v = 31'd1057095000;
            5'd19: v = 31'd1040706261;
            5'd20: v = 31'd1008687096;
            5'd21: v = 31'd947573834;
            5'd22: v = 31'd836230973;
            5'd23: v = 31'd651257337;
            5'd24: v = 31'd395007542;
            5'd25: v = 31'd145315154;
            5'd26: v = 31'd19666267;
            5'd27: v = 31'd360200;
            5'd28: v = 31'd121;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/sekcg_mul.sv @@
// ----------------------------------------------------------------------------
// sekcg_mul: shared registered multiplier
// Unsigned 33 x 33 product, registered: available in the cycle after the operands.
// ----------------------------------------------------------------------------
module sekcg_mul (
    input  logic        aclk,
    input  logic [32:0] op_a,
    input  logic [32:0] op_b,
    output logic [65:0] prod
);

    logic [65:0] prod_reg;
    logic [65:0] prod_next;

    // product of the current operands
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/sekcg_div.sv @@
// ----------------------------------------------------------------------------
// sekcg_div: iterative restoring divider
// One quotient bit per cycle; remainder starts below the divisor.
// ----------------------------------------------------------------------------
module sekcg_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  sekcg_pkg::div_req_t req,
    output sekcg_pkg::div_rsp_t rsp
);

    logic [61:0] rem_reg,  rem_next;
    logic [30:0] low_reg,  low_next;
    logic [30:0] quot_reg, quot_next;
    logic [61:0] den_reg,  den_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [62:0] shifted;
    logic [62:0] reduced;
    logic        fits;

    // one shift and trial subtract
    assign shifted = {rem_reg, low_reg[30]};
    assign reduced = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem_init;
            low_next  = req.low;
            quot_next = '0;
            den_next  = req.den;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? reduced[61:0] : shifted[61:0];
            low_next  = {low_reg[29:0], 1'b0};
            quot_next = {quot_reg[29:0], fits};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ rtl/core/se_kernel_covariance_grad.sv @@
// ----------------------------------------------------------------------------
// se_kernel_covariance_grad: squared-exponential kernel element engine
// Accumulates squared feature differences, then emits covariance and the
// vertical-scale and lengthscale gradients in Q8.24.
// ----------------------------------------------------------------------------
// A feature transaction without the last mark is squared on the shared
// multiplier, then accumulated. A marked transaction runs the L^2 product, a
// 30-step divide for the exponent, three table-driven exp evaluations of up
// to 29 multiply steps each on the one shared multiplier, five gradient
// products and a 31-step divide for the lengthscale gradient. The result
// sits in an output register, so the next pair is taken while it waits;
// s_ready is low while an item is in work.
module se_kernel_covariance_grad (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sekcg_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sekcg_pkg::out_item_t m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ, ST_DEN, ST_WAITX, ST_EXP_INIT, ST_EXP_STEP, ST_EXP_MUL,
        ST_P_COV, ST_P_GV, ST_P_Q1, ST_P_Q1W, ST_P_Q, ST_P_QW, ST_P_P, ST_P_PW,
        ST_WAITL, ST_FIN
    } state_t;

    typedef enum logic [1:0] {EXP_X, EXP_V, EXP_L} exp_sel_t;

    state_t   state_reg, state_next;
    exp_sel_t sel_reg,   sel_next;

    logic [30:0] len_reg,   len_next;
    logic [30:0] vert_reg,  vert_next;
    logic [30:0] noise_reg, noise_next;
    logic [47:0] acc_reg,   acc_next;
    logic        last_reg,  last_next;
    logic        diag_reg,  diag_next;
    logic [29:0] x_reg,     x_next;
    logic [30:0] eacc_reg,  eacc_next;
    logic [4:0]  ebit_reg,  ebit_next;
    logic [24:0] ex_reg,    ex_next;
    logic [24:0] ev_reg,    ev_next;
    logic [24:0] el_reg,    el_next;
    logic [31:0] cov_reg,   cov_next;
    logic [31:0] gv_reg,    gv_next;
    logic [31:0] gl_reg,    gl_next;
    logic [29:0] q_reg,     q_next;
    logic        mv_reg,    mv_next;
    sekcg_pkg::out_item_t md_reg, md_next;

    logic [32:0] diff, mag;
    logic [32:0] op_a, op_b;
    logic [65:0] prod;
    logic [65:0] rnd24_sum;
    logic [61:0] rnd30_sum;
    logic [48:0] acc_sum;
    logic [30:0] lraw;
    logic [30:0] exp_arg;
    logic [24:0] exp_res;
    logic        exp_fin;
    logic [32:0] cov_sum;
    logic [61:0] num;
    logic [64:0] xnum;
    sekcg_pkg::div_req_t div_req;
    sekcg_pkg::div_rsp_t div_rsp;

    sekcg_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    sekcg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // difference magnitude of the incoming pair
    assign diff = {s_data.feature_a[31], s_data.feature_a}
                - {s_data.feature_b[31], s_data.feature_b};
    assign mag  = diff[32] ? (33'd0 - diff) : diff;

    // rounding of the registered product
    assign rnd24_sum = prod + 66'd8388608;
    assign rnd30_sum = prod[61:0] + 62'd536870912;

    assign acc_sum = {1'b0, acc_reg} + {8'd0, rnd24_sum[64:24]};
    assign lraw    = (len_reg == 31'd0) ? 31'd1 : len_reg;
    assign xnum    = {acc_reg, 17'd0};
    assign num     = {prod[60:0], 1'b0};
    // noise only on the diagonal
    assign cov_sum = {2'b0, rnd24_sum[54:24]} + {2'b0, (diag_reg ? noise_reg : 31'd0)};

    // operand of the exp sequence
    always_comb begin
        unique case (sel_reg)
            EXP_X:   exp_arg = {1'b0, x_reg};
            EXP_V:   exp_arg = vert_reg;
            EXP_L:   exp_arg = lraw;
            default: exp_arg = lraw;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        len_next   = len_reg;
        vert_next  = vert_reg;
        noise_next = noise_reg;
        acc_next   = acc_reg;
        last_next  = last_reg;
        diag_next  = diag_reg;
        x_next     = x_reg;
        eacc_next  = eacc_reg;
        ebit_next  = ebit_reg;
        ex_next    = ex_reg;
        ev_next    = ev_reg;
        el_next    = el_reg;
        cov_next   = cov_reg;
        gv_next    = gv_reg;
        gl_next    = gl_reg;
        q_next     = q_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        op_a       = '0;
        op_b       = '0;
        exp_fin    = 1'b0;
        exp_res    = '0;
        div_req    = '0;

        // configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                sekcg_pkg::CFG_LENGTH_SCALE:   len_next   = cfg_wdata;
                sekcg_pkg::CFG_VERTICAL_SCALE: vert_next  = cfg_wdata;
                sekcg_pkg::CFG_NOISE_LEVEL:    noise_next = cfg_wdata;
                default: ;
            endcase
        end

        // output register drains
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                op_a = mag;
                op_b = mag;
                if (s_valid) begin
                    last_next  = s_data.last_feature;
                    diag_next  = (s_data.point_row == s_data.point_col);
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                acc_next = acc_sum[48] ? '1 : acc_sum[47:0];
                op_a     = {2'b0, lraw};
                op_b     = {2'b0, lraw};
                state_next = last_reg ? ST_DEN : ST_IDLE;
            end
            ST_DEN: begin
                sel_next = EXP_X;
                if (xnum >= {3'b0, prod[61:0]}) begin
                    x_next     = sekcg_pkg::X_CAP;
                    state_next = ST_EXP_INIT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = xnum[61:0];
                    div_req.low      = '0;
                    div_req.iters    = sekcg_pkg::DIV_ITERS_X;
                    div_req.den      = prod[61:0];
                    state_next       = ST_WAITX;
                end
            end
            ST_WAITX: begin
                if (div_rsp.done) begin
                    x_next     = div_rsp.quot[29:0];
                    state_next = ST_EXP_INIT;
                end
            end
            ST_EXP_INIT: begin
                eacc_next = sekcg_pkg::ONE30;
                ebit_next = '0;
                if (exp_arg[30:29] != 2'b0) begin
                    exp_fin = 1'b1;
                    exp_res = '0;
                end else begin
                    state_next = ST_EXP_STEP;
                end
            end
            ST_EXP_STEP: begin
                if (ebit_reg == sekcg_pkg::EXP_BITS) begin
                    exp_fin = 1'b1;
                    exp_res = 25'((eacc_reg + 31'd32) >> 6);
                end else if (exp_arg[ebit_reg]) begin
                    op_a       = {2'b0, eacc_reg};
                    op_b       = {2'b0, sekcg_pkg::exp_tab(ebit_reg)};
                    state_next = ST_EXP_MUL;
                end else begin
                    ebit_next = ebit_reg + 5'd1;
                end
            end
            ST_EXP_MUL: begin
                eacc_next  = rnd30_sum[60:30];
                ebit_next  = ebit_reg + 5'd1;
                state_next = ST_EXP_STEP;
            end
            ST_P_COV: begin
                op_a       = {2'b0, vert_reg};
                op_b       = {8'd0, ex_reg};
                state_next = ST_P_GV;
            end
            ST_P_GV: begin
                cov_next   = cov_sum[32:31] != 2'b0 ? sekcg_pkg::SAT32 : cov_sum[31:0];
                op_a       = {8'd0, ex_reg};
                op_b       = {8'd0, sekcg_pkg::ONE24 - ev_reg};
                state_next = ST_P_Q1;
            end
            ST_P_Q1: begin
                gv_next    = {7'd0, rnd24_sum[48:24]};
                op_a       = {3'b0, x_reg};
                op_b       = {8'd0, ex_reg};
                state_next = ST_P_Q1W;
            end
            ST_P_Q1W: begin
                q_next     = rnd24_sum[53:24];
                state_next = ST_P_Q;
            end
            ST_P_Q: begin
                op_a       = {3'b0, q_reg};
                op_b       = {8'd0, sekcg_pkg::ONE24 - el_reg};
                state_next = ST_P_QW;
            end
            ST_P_QW: begin
                q_next     = rnd24_sum[53:24];
                state_next = ST_P_P;
            end
            ST_P_P: begin
                op_a       = {3'b0, q_reg};
                op_b       = {2'b0, vert_reg};
                state_next = ST_P_PW;
            end
            ST_P_PW: begin
                if (num[61:31] >= lraw) begin
                    gl_next    = sekcg_pkg::SAT32;
                    state_next = ST_FIN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = {31'd0, num[61:31]};
                    div_req.low      = num[30:0];
                    div_req.iters    = sekcg_pkg::DIV_ITERS_L;
                    div_req.den      = {31'd0, lraw};
                    state_next       = ST_WAITL;
                end
            end
            ST_WAITL: begin
                if (div_rsp.done) begin
                    gl_next    = {1'b0, div_rsp.quot};
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    md_next.covariance    = cov_reg;
                    md_next.grad_vertical = gv_reg;
                    md_next.grad_length   = gl_reg;
                    mv_next               = 1'b1;
                    acc_next              = '0;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // store an exp result and move to the next argument
        if (exp_fin) begin
            unique case (sel_reg)
                EXP_X: begin
                    ex_next    = exp_res;
                    sel_next   = EXP_V;
                    state_next = ST_EXP_INIT;
                end
                EXP_V: begin
                    ev_next    = exp_res;
                    sel_next   = EXP_L;
                    state_next = ST_EXP_INIT;
                end
                default: begin
                    el_next    = exp_res;
                    state_next = ST_P_COV;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= EXP_X;
            len_reg   <= sekcg_pkg::LENGTH_RESET;
            vert_reg  <= sekcg_pkg::VERTICAL_RESET;
            noise_reg <= sekcg_pkg::NOISE_RESET;
            acc_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            len_reg   <= len_next;
            vert_reg  <= vert_next;
            noise_reg <= noise_next;
            acc_reg   <= acc_next;
            mv_reg    <= mv_next;
        end
        last_reg <= last_next;
        diag_reg <= diag_next;
        x_reg    <= x_next;
        eacc_reg <= eacc_next;
        ebit_reg <= ebit_next;
        ex_reg   <= ex_next;
        ev_reg   <= ev_next;
        el_reg   <= el_next;
        cov_reg  <= cov_next;
        gv_reg   <= gv_next;
        gl_reg   <= gl_next;
        q_reg    <= q_next;
        md_reg   <= md_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the squared-exponential kernel engine
// Streams feature pairs through several lengthscale, vertical-scale and noise
// settings, predicts covariance and both gradients per marked transaction in
// Q8.24 and compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index

    typedef enum int {FEAT_SMALL, FEAT_FULL, FEAT_EQUAL, FEAT_NEAR} feat_kind_t;

    // exp(-2^(i-24)) in Q.30
    localparam longint unsigned EXP_STEP [29] = '{
        64'd1073741760, 64'd1073741696, 64'd1073741568, 64'd1073741312,
        64'd1073740800, 64'd1073739776, 64'd1073737728, 64'd1073733632,
        64'd1073725440, 64'd1073709056, 64'd1073676290, 64'd1073610760,
        64'd1073479712, 64'd1073217664, 64'd1072693760, 64'd1071646719,
        64'd1069555701, 64'd1065385899, 64'd1057095000, 64'd1040706261,
        64'd1008687096, 64'd947573834,  64'd836230973,  64'd651257337,
        64'd395007542,  64'd145315154,  64'd19666267,   64'd360200,
        64'd121
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    sekcg_pkg::in_item_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    sekcg_pkg::out_item_t m_data;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [30:0]          cfg_wdata = '0;

    se_kernel_covariance_grad u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // mirrored configuration and accumulator state
    logic [30:0] lscale_q = sekcg_pkg::LENGTH_RESET;
    logic [30:0] vscale_q = sekcg_pkg::VERTICAL_RESET;
    logic [30:0] noise_q  = sekcg_pkg::NOISE_RESET;
    logic [47:0] sqdist_acc = '0;

    sekcg_pkg::in_item_t  feature_q[$];
    sekcg_pkg::out_item_t kernel_exp_q[$];

    int unsigned errors = 0;
    int unsigned n_items = 0;
    int unsigned n_results = 0;
    int unsigned n_diag = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    bit          rx_hold_on = 1'b0;
    bit          no_idle = 1'b0;

    function automatic longint unsigned mul_q24(longint unsigned a, longint unsigned b);
        return (a * b + 64'd8388608) >> 24;
    endfunction

    // exp(-x) in Q.24 from per-bit table products
    function automatic longint unsigned exp_neg_q24(longint unsigned x);
        longint unsigned acc;
        acc = 64'd1 << 30;
        if (x >> 29)
            return 0;
        for (int i = 0; i < 29; i++)
            if (x[i])
                acc = (acc * EXP_STEP[i] + (64'd1 << 29)) >> 30;
        return (acc + 64'd32) >> 6;
    endfunction

    function automatic longint unsigned sat_q24(longint unsigned v);
        return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
    endfunction

    // accumulate one feature pair, compute kernel and gradients on the last one
    function automatic void kernel_predict(sekcg_pkg::in_item_t it);
        logic signed [32:0]   diff;
        logic [32:0]          mag;
        logic [65:0]          sq;
        logic [48:0]          sum;
        logic [95:0]          quot;
        longint unsigned      lraw, x, e, cov, gv, q, gl;
        sekcg_pkg::out_item_t r;
        diff = 33'(it.feature_a) - 33'(it.feature_b);
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
        sq   = (66'(mag) * 66'(mag) + 66'd8388608) >> 24;
        sum  = 49'(sqdist_acc) + 49'(sq);
        sqdist_acc = (sq > 66'hFFFF_FFFF_FFFF || sum[48]) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
        if (!it.last_feature)
            return;
        lraw = (lscale_q == 0) ? 64'd1 : 64'(lscale_q);
        quot = (96'(sqdist_acc) << 47) / 96'(lraw * lraw);
        x    = (quot > 96'h3FFF_FFFF) ? 64'h3FFF_FFFF : 64'(quot);
        e    = exp_neg_q24(x);
        cov  = mul_q24(64'(vscale_q), e);
        if (it.point_row == it.point_col) begin
            cov += 64'(noise_q);
            n_diag++;
        end
        gv = mul_q24(e, (64'd1 << 24) - exp_neg_q24(64'(vscale_q)));
        q  = mul_q24(mul_q24(x, e), (64'd1 << 24) - exp_neg_q24(lraw));
        gl = (64'd2 * q * 64'(vscale_q)) / lraw;
        r.covariance    = 32'(sat_q24(cov));
        r.grad_vertical = 32'(sat_q24(gv));
        r.grad_length   = 32'(sat_q24(gl));
        kernel_exp_q.insert(kernel_exp_q.size(), r);
        sqdist_acc = '0;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch @%0t result %0d %s: got %h expected %h",
                 $realtime, n_results, what, got, want);
    endtask

    // driver: feature transactions from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                kernel_predict(s_data);
                n_items++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (feature_q.size() > 0) begin
                    s_data  <= feature_q.pop_front();
                    s_valid <= 1'b1;
                    tx_gap  <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: result transactions against the expected queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (kernel_exp_q.size() == 0) begin
                    report_mismatch("unexpected", m_data.covariance, '0);
                end else begin
                    sekcg_pkg::out_item_t w;
                    w = kernel_exp_q.pop_front();
                    if (m_data.covariance !== w.covariance)
                        report_mismatch("covariance", m_data.covariance, w.covariance);
                    if (m_data.grad_vertical !== w.grad_vertical)
                        report_mismatch("grad_vertical", m_data.grad_vertical,
                                        w.grad_vertical);
                    if (m_data.grad_length !== w.grad_length)
                        report_mismatch("grad_length", m_data.grad_length, w.grad_length);
                end
                n_results++;
            end
            if (rx_hold_on) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready)
                    rx_gap <= pick_gap();
            end
        end
    end

    // register write while idle, mirror updated alongside
    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sekcg_pkg::CFG_LENGTH_SCALE:   lscale_q = val;
            sekcg_pkg::CFG_VERTICAL_SCALE: vscale_q = val;
            sekcg_pkg::CFG_NOISE_LEVEL:    noise_q  = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [31:0] feat_value(feat_kind_t kind, logic [31:0] other);
        case (kind)
            FEAT_FULL:  return $urandom;
            FEAT_EQUAL: return other;
            FEAT_NEAR:  return other + ($signed($urandom) >>> $urandom_range(6, 20));
            default:    return $signed($urandom) >>> $urandom_range(5, 14);
        endcase
    endfunction

    function automatic void push_feat(logic [31:0] a, logic [31:0] b, bit last,
                                      logic [15:0] row, logic [15:0] col);
        sekcg_pkg::in_item_t it;
        it.feature_a    = a;
        it.feature_b    = b;
        it.last_feature = last;
        it.point_row    = row;
        it.point_col    = col;
        feature_q.insert(feature_q.size(), it);
    endfunction

    // one point pair: nfeat features, the last one marked
    function automatic void push_pair(int unsigned nfeat, feat_kind_t kind);
        logic [15:0] row, col;
        logic [31:0] a, b;
        feat_kind_t  k;
        row = 16'($urandom);
        col = ($urandom_range(0, 9) < 3) ? row : 16'($urandom);
        for (int unsigned i = 0; i < nfeat; i++) begin
            k = kind;
            if (kind == FEAT_SMALL && $urandom_range(0, 3) == 0)
                k = FEAT_NEAR;
            a = feat_value(FEAT_SMALL, '0);
            if (k == FEAT_FULL)
                a = $urandom;
            b = (k == FEAT_SMALL) ? feat_value(FEAT_SMALL, '0) : feat_value(k, a);
            push_feat(a, b, i == nfeat - 1, row, col);
        end
    endfunction

    // mostly well-formed pairs, some raw noise with random marks
    task automatic random_batch(int unsigned n);
        int unsigned added;
        int unsigned r;
        added = 0;
        while (added < n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                push_feat($urandom, $urandom, 1'($urandom_range(0, 1)),
                          16'($urandom), 16'($urandom));
                added++;
            end else begin
                int unsigned nf;
                nf = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64)
                                                  : $urandom_range(1, 8);
                if (r < 23)
                    push_pair(nf, FEAT_FULL);
                else if (r < 28)
                    push_pair(nf, FEAT_EQUAL);
                else
                    push_pair(nf, FEAT_SMALL);
                added += nf;
            end
        end
    endtask

    task automatic wait_drained();
        while (feature_q.size() != 0 || s_valid || kernel_exp_q.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // test sequence
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, diagonal, zero distance, accumulation
        push_feat(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd0, 16'd0);
        push_feat(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 16'd0);
        push_feat(32'h0100_0000, 32'h0100_0000, 1'b1, 16'hFFFF, 16'hFFFF);
        push_feat(32'h8000_0000, 32'h8000_0000, 1'b1, 16'h1234, 16'h4321);
        push_feat(32'h0080_0000, 32'h0000_0000, 1'b0, 16'd7, 16'd7);
        push_feat(32'hFF80_0000, 32'h0000_0000, 1'b0, 16'd7, 16'd7);
        push_feat(32'h0000_0001, 32'h0000_0000, 1'b1, 16'd7, 16'd7);
        push_feat(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 16'd3, 16'd9);
        push_feat(32'h00C0_0000, 32'hFF40_0000, 1'b1, 16'hAAAA, 16'h5555);
        push_feat(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'h5555, 16'hAAAA);
        push_feat(32'h0200_0000, 32'h0180_0000, 1'b1, 16'h8000, 16'h8000);
        push_feat(32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0001, 16'h0002);
        random_batch(240);
        wait_drained();

        // phase: larger lengthscale, no noise
        write_reg(sekcg_pkg::CFG_LENGTH_SCALE, 31'd67108864);
        write_reg(sekcg_pkg::CFG_VERTICAL_SCALE, 31'd41943040);
        write_reg(sekcg_pkg::CFG_NOISE_LEVEL, 31'd0);
        random_batch(250);
        wait_drained();

        // phase: zero lengthscale, top vertical scale and noise, no idling
        write_reg(sekcg_pkg::CFG_LENGTH_SCALE, 31'd0);
        write_reg(sekcg_pkg::CFG_VERTICAL_SCALE, 31'h7FFF_FFFF);
        write_reg(sekcg_pkg::CFG_NOISE_LEVEL, 31'h7FFF_FFFF);
        @(negedge aclk);
        no_idle = 1'b1;
        random_batch(200);
        push_feat(32'h0000_0000, 32'h0000_0000, 1'b1, 16'd5, 16'd5);
        wait_drained();
        @(negedge aclk);
        no_idle = 1'b0;

        // phase: top lengthscale, zero vertical scale, saturating sum
        write_reg(sekcg_pkg::CFG_LENGTH_SCALE, 31'h7FFF_FFFF);
        write_reg(sekcg_pkg::CFG_VERTICAL_SCALE, 31'd0);
        write_reg(sekcg_pkg::CFG_NOISE_LEVEL, 31'd1);
        for (int i = 0; i < 299; i++)
            push_feat(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd1, 16'd1);
        push_feat(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd1, 16'd1);
        random_batch(100);
        wait_drained();

        // phase: short lengthscale, smallest nonzero vertical scale, spare index ignored
        write_reg(sekcg_pkg::CFG_LENGTH_SCALE, 31'd4194304);
        write_reg(sekcg_pkg::CFG_VERTICAL_SCALE, 31'd1);
        write_reg(sekcg_pkg::CFG_NOISE_LEVEL, 31'd1048576);
        write_reg(CFG_SPARE, 31'h7FFF_FFFF);
        random_batch(200);
        wait_drained();

        // phase: defaults again, receiver held off while the sender keeps going
        write_reg(sekcg_pkg::CFG_LENGTH_SCALE, sekcg_pkg::LENGTH_RESET);
        write_reg(sekcg_pkg::CFG_VERTICAL_SCALE, sekcg_pkg::VERTICAL_RESET);
        write_reg(sekcg_pkg::CFG_NOISE_LEVEL, sekcg_pkg::NOISE_RESET);
        fork
            begin
                @(negedge aclk);
                rx_hold_on = 1'b1;
                repeat (600) @(negedge aclk);
                rx_hold_on = 1'b0;
            end
        join_none
        random_batch(250);
        wait_drained();

        $display("covered %0d feature transactions, %0d kernel results (%0d diagonal)",
                 n_items, n_results, n_diag);
        $display("register setups: default, zero/top lengthscale, zero/top vertical scale "
                 + "and noise");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
